@@ design/swtm_pkg.sv @@
// Shared types and constants for the sliding-window trimmed-mean filter.
// Used by swtm_cell, swtm_mean and sliding_window_trimmed_mean; no dependencies.
`default_nettype none

package swtm_pkg;

   localparam int WINDOW      = 16;
   localparam int SAMPLE_W    = 24;
   localparam int TRIM_COUNT  = 5;
   localparam int RANK_LO     = WINDOW / 2 - 2;
   localparam int COUNT_W     = $clog2(WINDOW + 1);

   // Five 24-bit samples need three extra bits; the magnitude one fewer.
   localparam int SUM_W       = SAMPLE_W + 3;
   localparam int MAG_W       = SUM_W - 1;

   // Reciprocal of five, exact for any unsigned operand of up to 32 bits.
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 34;
   localparam int PROD_W      = MAG_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_FIVE = 32'hCCCC_CCCD;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Compare flags that each cell shows its neighbors.
   typedef struct packed {
      logic above_old;   // stored value is greater than the evicted sample
      logic ge_new;      // stored value is at least the incoming sample
   } link_type;

endpackage

`default_nettype wire

@@ design/sliding_window_trimmed_mean.sv @@
// Top level of the sliding-window trimmed-mean filter: sorted cell chain and mean pipeline.
// Depends on swtm_pkg, swtm_cell and swtm_mean.
//
//   Channel   Direction  Handshake             Beat contents
//   req_      in         req_valid/req_stall   sample (signed 24 bits)
//   rsp_      out        rsp_valid/rsp_stall   filtered_value (signed 24), window_full
//
// One beat is accepted per cycle while the response is not stalled; throughput is one
// sample per clock, set by the combined insert and evict step of the sorted cell chain.
// An accepted request reaches the response through the chain update register, then
// the sum, magnitude, reciprocal multiply and sign restore stages.
// Reset is synchronous and clears the window to zero, so a fresh block sorts zeros.
// A stalled response freezes the whole pipeline; req_stall rises in the same cycle.
`default_nettype none

module sliding_window_trimmed_mean
   import swtm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire sample_type req_sample,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output sample_type      rsp_filtered_value,
   output logic            rsp_window_full
);

   // The pipeline moves as a whole whenever the output register can take a beat.
   logic advance;
   logic accept;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   // Each cell holds one rank of the sorted window and one tap of the history
   // line. The last history tap is the sample that leaves the window when the
   // next one comes in. Cells only look at their immediate neighbors: a cell
   // whose value exceeds the departing sample stays put, others close the gap
   // from below, and the new sample drops in where the compare flags change.
   sample_type val_w  [WINDOW];
   link_type   link_w [WINDOW];
   sample_type hist_w [WINDOW];
   sample_type old_sample;

   assign old_sample = hist_w[WINDOW-1];

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      sample_type up_val, dn_val, up_hist;
      link_type   up_link, dn_link;

      if (i == 0) begin : g_top
         // Above the first rank sits an imaginary entry that beats everything.
         assign up_val  = '0;
         assign up_link = '{above_old: 1'b1, ge_new: 1'b1};
         assign up_hist = req_sample;
      end else begin : g_mid_up
         assign up_val  = val_w[i-1];
         assign up_link = link_w[i-1];
         assign up_hist = hist_w[i-1];
      end

      if (i == WINDOW - 1) begin : g_bottom
         // Below the last rank is the hole left by eviction; it never wins.
         assign dn_val  = '0;
         assign dn_link = '{above_old: 1'b0, ge_new: 1'b0};
      end else begin : g_mid_dn
         assign dn_val  = val_w[i+1];
         assign dn_link = link_w[i+1];
      end

      swtm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load       (accept),
         .sample     (req_sample),
         .old_sample (old_sample),
         .up_val     (up_val),
         .up_link    (up_link),
         .up_hist    (up_hist),
         .dn_val     (dn_val),
         .dn_link    (dn_link),
         .val        (val_w[i]),
         .link       (link_w[i]),
         .hist       (hist_w[i])
      );
   end

   // Fill counter saturates at the window length; the full flag follows the item.
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               chain_valid_ff;
   logic               chain_full_ff;

   assign count_in = (count_ff == COUNT_W'(WINDOW)) ? count_ff : count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         chain_valid_ff <= 1'b0;
         chain_full_ff  <= 1'b0;
      end else if (advance) begin
         chain_valid_ff <= accept;
         if (accept) begin
            count_ff      <= count_in;
            chain_full_ff <= (count_in == COUNT_W'(WINDOW));
         end
      end
   end

   // The five middle ranks of the freshly sorted window feed the mean.
   sample_type mid_vals [TRIM_COUNT];

   for (genvar k = 0; k < TRIM_COUNT; k++) begin : g_mid
      assign mid_vals[k] = val_w[RANK_LO + k];
   end

   swtm_mean u_mean (
      .clock              (clock),
      .reset              (reset),
      .advance            (advance),
      .in_valid           (chain_valid_ff),
      .in_full            (chain_full_ff),
      .mid_vals           (mid_vals),
      .rsp_valid          (rsp_valid),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_window_full    (rsp_window_full)
   );

endmodule

`default_nettype wire

@@ design/swtm_cell.sv @@
// One slot of the sorted chain plus one tap of the sample history line.
// Depends on swtm_pkg.
`default_nettype none

module swtm_cell
   import swtm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire sample_type sample,
   input  wire sample_type old_sample,
   input  wire sample_type up_val,
   input  wire link_type   up_link,
   input  wire sample_type up_hist,
   input  wire sample_type dn_val,
   input  wire link_type   dn_link,
   output sample_type      val,
   output link_type        link,
   output sample_type      hist
);

   sample_type val_ff, val_in;
   sample_type hist_ff;
   sample_type keep_val, up_keep_val;
   logic       keep_ge, up_keep_ge;

   assign link.above_old = (val_ff > old_sample);
   assign link.ge_new    = (val_ff >= sample);

   // After the evicted entry is closed up, this slot would hold keep_val.
   // The chain above and below this slot moves by at most one place.
   always_comb begin
      keep_val    = link.above_old ? val_ff : dn_val;
      keep_ge     = link.above_old ? link.ge_new : dn_link.ge_new;
      up_keep_val = up_link.above_old ? up_val : val_ff;
      up_keep_ge  = up_link.above_old ? up_link.ge_new : link.ge_new;
      if (keep_ge) begin
         val_in = keep_val;
      end else if (up_keep_ge) begin
         val_in = sample;
      end else begin
         val_in = up_keep_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff  <= '0;
         hist_ff <= '0;
      end else if (load) begin
         val_ff  <= val_in;
         hist_ff <= up_hist;
      end
   end

   assign val  = val_ff;
   assign hist = hist_ff;

endmodule

`default_nettype wire

@@ design/swtm_mean.sv @@
// Sum of the five middle ranks and a signed divide by five, four register stages.
// Depends on swtm_pkg.
`default_nettype none

module swtm_mean
   import swtm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       in_valid,
   input  wire logic       in_full,
   input  wire sample_type mid_vals [TRIM_COUNT],
   output logic            rsp_valid,
   output sample_type      rsp_filtered_value,
   output logic            rsp_window_full
);

   logic signed [SUM_W-1:0] sum_in, sum_ff;
   logic                    sum_valid_ff, sum_full_ff;
   logic [MAG_W-1:0]        mag_in, mag_ff;
   logic                    neg_ff, mag_valid_ff, mag_full_ff;
   logic signed [SUM_W-1:0] neg_sum;
   logic [PROD_W-1:0]       prod_in, prod_ff;
   logic                    prod_neg_ff, prod_valid_ff, prod_full_ff;
   logic [SAMPLE_W-1:0]     quot;
   sample_type              out_in, out_ff;
   logic                    out_valid_ff, out_full_ff;

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < TRIM_COUNT; k++) begin
         sum_in = sum_in + SUM_W'(mid_vals[k]);
      end
   end

   assign neg_sum = -sum_ff;
   assign mag_in  = sum_ff[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_ff[MAG_W-1:0];
   assign prod_in = PROD_W'(mag_ff) * PROD_W'(RECIP_FIVE);
   assign quot    = prod_ff[RECIP_SHIFT +: SAMPLE_W];
   assign out_in  = prod_neg_ff ? sample_type'(-quot) : sample_type'(quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff  <= 1'b0;
         mag_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         sum_valid_ff  <= in_valid;
         mag_valid_ff  <= sum_valid_ff;
         prod_valid_ff <= mag_valid_ff;
         out_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff      <= sum_in;
         sum_full_ff <= in_full;
         mag_ff      <= mag_in;
         neg_ff      <= sum_ff[SUM_W-1];
         mag_full_ff <= sum_full_ff;
         prod_ff     <= prod_in;
         prod_neg_ff <= neg_ff;
         prod_full_ff <= mag_full_ff;
         out_ff      <= out_in;
         out_full_ff <= prod_full_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_filtered_value = out_ff;
   assign rsp_window_full    = out_full_ff;

endmodule

`default_nettype wire
